@@ rtl/core/vcr_pkg.sv @@
`timescale 1ns / 1ps

package vcr_pkg;

    localparam int SCREEN_WORDS = 32768;
    localparam int SYNC_DEPTH   = 4096;

    localparam int ACTION_W = 3;
    localparam int OFFSET_W = 15;
    localparam int DATA_W   = 32;
    localparam int SYNC_W   = 8;
    localparam int PTR_W    = 12;

    localparam int SCR_AW  = $clog2(SCREEN_WORDS);
    localparam int SYNC_AW = $clog2(SYNC_DEPTH);

    // one sweep covers the larger of the two memories
    localparam int CLR_LEN = (SCREEN_WORDS > SYNC_DEPTH) ? SCREEN_WORDS : SYNC_DEPTH;
    localparam int CLR_AW  = $clog2(CLR_LEN);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SCR_RD  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SCR_WR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CTL_RD  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CTL_WR  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_VSYNC   = 3'd4;

    // control register offsets
    localparam logic [OFFSET_W-1:0] REG_MODE    = 15'd0;
    localparam logic [OFFSET_W-1:0] REG_SYNC    = 15'd1;
    localparam logic [OFFSET_W-1:0] REG_PTR     = 15'd2;
    localparam logic [OFFSET_W-1:0] REG_SPACING = 15'd3;

    // mode and spacing bits
    localparam int MODE_INTR_EN_BIT  = 3;
    localparam int MODE_VERT_BIT     = 4;
    localparam int SPACING_PROM_BIT  = 7;

    // where the read word of a pending result comes from
    typedef enum logic [1:0] {
        SEL_IMM  = 2'd0,
        SEL_SCR  = 2'd1,
        SEL_SYNC = 2'd2
    } t_sel;

    typedef struct packed {
        t_sel              sel;
        logic [DATA_W-1:0] imm;
        logic              err;
        logic              irq;
    } t_meta;

endpackage

@@ rtl/core/vcr_ram.sv @@
`timescale 1ns / 1ps

module vcr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/video_controller_registers.sv @@
`timescale 1ns / 1ps

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_action, i_offset, i_write_data
// out      | o_out_valid  | i_out_stall  | o_read_data, o_bus_error, o_interrupt_pulse
//
// One word accepted per cycle while o_in_stall is low; its result passes through the registered read
// of the screen or sync memory, then through the output register.
// After reset a clearing sweep writes zeros to both memories;
// o_in_stall is high throughout. Reset is synchronous, active low.
// A stalled output holds its word while one more word may wait in the read stage.

module video_controller_registers (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vcr_pkg::ACTION_W-1:0]  i_action,
    input  logic [vcr_pkg::OFFSET_W-1:0]  i_offset,
    input  logic [vcr_pkg::DATA_W-1:0]    i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vcr_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_bus_error,
    output logic                          o_interrupt_pulse
);

    import vcr_pkg::*;

    logic              r_clr_busy;
    logic [CLR_AW-1:0] r_clr_addr;
    logic [DATA_W-1:0] r_mode;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_prom_dis;
    logic              r_p_valid;
    t_meta             r_p_meta;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_data;
    logic              r_o_err;
    logic              r_o_irq;

    logic [DATA_W-1:0] n_mode;
    logic [PTR_W-1:0]  n_ptr;
    logic              n_prom_dis;
    t_meta             n_meta;

    logic              acc;
    logic              mv;
    logic              scr_we;
    logic              scr_re;
    logic [SCR_AW-1:0] scr_addr;
    logic [DATA_W-1:0] scr_wdata;
    logic [DATA_W-1:0] scr_rdata;
    logic              sync_we;
    logic              sync_re;
    logic [SYNC_AW-1:0] sync_addr;
    logic [SYNC_W-1:0] sync_wdata;
    logic [SYNC_W-1:0] sync_rdata;
    logic [DATA_W-1:0] p_word;

    assign mv         = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_p_valid && !mv);
    assign acc        = i_in_valid && !o_in_stall;

    // decode of the accepted word
    always_comb begin
        n_mode     = r_mode;
        n_ptr      = r_ptr;
        n_prom_dis = r_prom_dis;
        n_meta     = '{sel: SEL_IMM, imm: '0, err: 1'b0, irq: 1'b0};
        scr_we     = 1'b0;
        scr_re     = 1'b0;
        sync_we    = 1'b0;
        sync_re    = 1'b0;
        unique case (i_action)
            ACT_SCR_RD: begin
                scr_re     = acc;
                n_meta.sel = SEL_SCR;
            end
            ACT_SCR_WR: begin
                scr_we = acc;
            end
            ACT_CTL_RD: begin
                if (i_offset == REG_MODE) begin
                    n_meta.imm = r_mode;
                end else if (i_offset == REG_SYNC) begin
                    // PROM enabled: sync data reads as zero
                    if (r_prom_dis) begin
                        sync_re    = acc;
                        n_meta.sel = SEL_SYNC;
                    end
                end else begin
                    n_meta.err = 1'b1;
                end
            end
            ACT_CTL_WR: begin
                if (i_offset == REG_MODE) begin
                    n_mode = i_write_data;
                end else if (i_offset == REG_SYNC) begin
                    sync_we = acc && r_prom_dis;
                end else if (i_offset == REG_PTR) begin
                    n_ptr = i_write_data[PTR_W-1:0];
                end else if (i_offset == REG_SPACING) begin
                    n_prom_dis = i_write_data[SPACING_PROM_BIT];
                end else begin
                    n_meta.err = 1'b1;
                end
            end
            ACT_VSYNC: begin
                if (r_mode[MODE_INTR_EN_BIT]) begin
                    n_mode[MODE_VERT_BIT] = 1'b1;
                    n_meta.irq            = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (r_clr_busy) begin
            scr_we  = 1'b1;
            sync_we = 1'b1;
        end
    end

    assign scr_addr   = r_clr_busy ? r_clr_addr[SCR_AW-1:0] : i_offset[SCR_AW-1:0];
    assign scr_wdata  = r_clr_busy ? '0 : i_write_data;
    assign sync_addr  = r_clr_busy ? r_clr_addr[SYNC_AW-1:0] : r_ptr[SYNC_AW-1:0];
    assign sync_wdata = r_clr_busy ? '0 : i_write_data[SYNC_W-1:0];

    vcr_ram #(
        .DEPTH (SCREEN_WORDS),
        .WIDTH (DATA_W)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_re    (scr_re),
        .i_addr  (scr_addr),
        .i_wdata (scr_wdata),
        .o_rdata (scr_rdata)
    );

    vcr_ram #(
        .DEPTH (SYNC_DEPTH),
        .WIDTH (SYNC_W)
    ) u_sync (
        .i_clk   (i_clk),
        .i_we    (sync_we),
        .i_re    (sync_re),
        .i_addr  (sync_addr),
        .i_wdata (sync_wdata),
        .o_rdata (sync_rdata)
    );

    always_comb begin
        case (r_p_meta.sel)
            SEL_SCR:  p_word = scr_rdata;
            SEL_SYNC: p_word = {{(DATA_W-SYNC_W){1'b0}}, sync_rdata};
            default:  p_word = r_p_meta.imm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_mode     <= '0;
            r_ptr      <= '0;
            r_prom_dis <= 1'b0;
            r_p_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CLR_AW'(1);
                if (r_clr_addr == CLR_AW'(CLR_LEN - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (acc) begin
                r_mode     <= n_mode;
                r_ptr      <= n_ptr;
                r_prom_dis <= n_prom_dis;
                r_p_valid  <= 1'b1;
            end else if (mv) begin
                r_p_valid <= 1'b0;
            end
            if (mv) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_meta <= n_meta;
        end
        if (mv) begin
            r_o_data <= p_word;
            r_o_err  <= r_p_meta.err;
            r_o_irq  <= r_p_meta.irq;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_read_data       = r_o_data;
    assign o_bus_error       = r_o_err;
    assign o_interrupt_pulse = r_o_irq;

`ifndef NO_ASSERTIONS
    a_no_acc_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && acc))
        else $error("word accepted during memory clear");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !mv) |=> r_p_valid)
        else $error("pending read result dropped");

    a_vsync_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_action == ACT_VSYNC && r_mode[MODE_INTR_EN_BIT]) |=> r_mode[MODE_VERT_BIT])
        else $error("vertical flag not set on interrupt");

    a_err_irq_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_err && r_o_irq))
        else $error("bus error and interrupt in one word");

    a_mem_idle_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && !r_clr_busy) |-> !(scr_we || scr_re || sync_we || sync_re))
        else $error("memory access without accepted word");
`endif

endmodule

@@ bench/video_controller_registers_tb.sv @@
`timescale 1ns / 1ps

module video_controller_registers_tb;

    import vcr_pkg::*;

    localparam int          CLK_HALF_NS    = 6;
    localparam int          RESET_CYCLES   = 8;
    localparam int          RANDOM_WORDS   = 1550;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          TIMEOUT_CYCLES = 400_000;
    localparam int unsigned SCR_POOL_N     = 24;
    localparam int unsigned PTR_POOL_N     = 12;

    // action codes the block does nothing with
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = ACT_VSYNC + ACTION_W'(1);
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = {ACTION_W{1'b1}};
    // first control offset with no register behind it
    localparam logic [OFFSET_W-1:0] REG_FIRST_BAD = REG_SPACING + OFFSET_W'(1);
    localparam logic [OFFSET_W-1:0] OFFSET_MAX    = {OFFSET_W{1'b1}};

    localparam logic [DATA_W-1:0] INTR_EN_WORD  = DATA_W'(1) << MODE_INTR_EN_BIT;
    localparam logic [DATA_W-1:0] PROM_OFF_WORD = DATA_W'(1) << SPACING_PROM_BIT;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
    } t_bus_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bus_error;
        logic              irq;
    } t_bus_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action = '0;
    logic [OFFSET_W-1:0] i_offset = '0;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_bus_error;
    logic                o_interrupt_pulse;

    // shadow of the controller state
    logic [DATA_W-1:0] screen_mem [SCREEN_WORDS];
    logic [SYNC_W-1:0] sync_mem [SYNC_DEPTH];
    logic [DATA_W-1:0] mode_word;
    logic [PTR_W-1:0]  sync_ptr;
    logic              prom_off;

    t_bus_word   bus_words[$];
    t_bus_result pending_results[$];
    t_bus_word   cur_word;

    int unsigned total_words = 0;
    int unsigned words_issued = 0;
    int unsigned words_accepted = 0;
    int unsigned busy_words = 0;
    int unsigned mismatch_count = 0;

    video_controller_registers u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_offset          (i_offset),
        .i_write_data      (i_write_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_read_data       (o_read_data),
        .o_bus_error       (o_bus_error),
        .o_interrupt_pulse (o_interrupt_pulse)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_bus_result predict_bus_result(t_bus_word w);
        t_bus_result r;
        int unsigned sidx;
        r = '0;
        sidx = int'(sync_ptr) % SYNC_DEPTH;
        case (w.action)
            ACT_SCR_RD: r.read_data = screen_mem[int'(w.offset) % SCREEN_WORDS];
            ACT_SCR_WR: screen_mem[int'(w.offset) % SCREEN_WORDS] = w.data;
            ACT_CTL_RD: begin
                if (w.offset == REG_MODE) begin
                    r.read_data = mode_word;
                end else if (w.offset == REG_SYNC) begin
                    r.read_data = prom_off ? DATA_W'(sync_mem[sidx]) : '0;
                end else begin
                    r.bus_error = 1'b1;
                end
            end
            ACT_CTL_WR: begin
                if (w.offset == REG_MODE) begin
                    mode_word = w.data;
                end else if (w.offset == REG_SYNC) begin
                    if (prom_off) begin
                        sync_mem[sidx] = w.data[SYNC_W-1:0];
                    end
                end else if (w.offset == REG_PTR) begin
                    sync_ptr = w.data[PTR_W-1:0];
                end else if (w.offset == REG_SPACING) begin
                    prom_off = w.data[SPACING_PROM_BIT];
                end else begin
                    r.bus_error = 1'b1;
                end
            end
            ACT_VSYNC: begin
                if (mode_word[MODE_INTR_EN_BIT]) begin
                    mode_word[MODE_VERT_BIT] = 1'b1;
                    r.irq = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // sender idles 18% then 84% then never; receiver the other way round
    function automatic int unsigned idle_pct(bit sender);
        if (words_issued < total_words / 3) begin
            return sender ? 18 : 84;
        end else if (words_issued < 2 * total_words / 3) begin
            return sender ? 84 : 18;
        end
        return 0;
    endfunction

    task automatic push_word(logic [ACTION_W-1:0] action, logic [OFFSET_W-1:0] offset,
                             logic [DATA_W-1:0] data);
        t_bus_word w;
        w.action = action;
        w.offset = offset;
        w.data   = data;
        bus_words.push_back(w);
        if (action <= ACT_VSYNC) begin
            busy_words++;
        end
    endtask

    always @(posedge i_clk) begin : driver
        t_bus_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(predict_bus_result(cur_word));
                words_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (bus_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    w = bus_words.pop_front();
                    cur_word = w;
                    words_issued++;
                    i_in_valid   <= 1'b1;
                    i_action     <= w.action;
                    i_offset     <= w.offset;
                    i_write_data <= w.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_bus_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word: read_data %h bus_error %b irq %b", $time,
                             o_read_data, o_bus_error, o_interrupt_pulse);
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_data !== want.read_data) begin
                        mismatch_count++;
                        $display("%0t: read_data expected %h got %h", $time,
                                 want.read_data, o_read_data);
                    end
                    if (o_bus_error !== want.bus_error) begin
                        mismatch_count++;
                        $display("%0t: bus_error expected %b got %b", $time,
                                 want.bus_error, o_bus_error);
                    end
                    if (o_interrupt_pulse !== want.irq) begin
                        mismatch_count++;
                        $display("%0t: interrupt_pulse expected %b got %b", $time,
                                 want.irq, o_interrupt_pulse);
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    initial begin : stimulus
        logic [OFFSET_W-1:0] scr_pool [SCR_POOL_N];
        logic [PTR_W-1:0]    ptr_pool [PTR_POOL_N];
        logic [OFFSET_W-1:0] addr;
        logic [PTR_W-1:0]    ptr;
        logic [DATA_W-1:0]   d;
        int unsigned         pick;

        foreach (screen_mem[i]) screen_mem[i] = '0;
        foreach (sync_mem[i]) sync_mem[i] = '0;
        mode_word = '0;
        sync_ptr  = '0;
        prom_off  = 1'b0;

        // directed: extremes, every action, register corners
        push_word(ACT_SCR_WR, '0, '1);
        push_word(ACT_SCR_WR, OFFSET_MAX, 32'hA5A5_5A5A);
        push_word(ACT_SCR_RD, '0, '0);
        push_word(ACT_SCR_RD, OFFSET_MAX, '1);
        push_word(ACT_CTL_RD, REG_MODE, '0);
        push_word(ACT_CTL_WR, REG_MODE, INTR_EN_WORD);
        push_word(ACT_VSYNC, '0, '0);
        push_word(ACT_CTL_RD, REG_MODE, '0);
        push_word(ACT_CTL_WR, REG_MODE, '0);
        push_word(ACT_VSYNC, OFFSET_MAX, '1);
        // sync data port while the PROM is still enabled
        push_word(ACT_CTL_WR, REG_PTR, '1);
        push_word(ACT_CTL_WR, REG_SYNC, 32'h0000_00C3);
        push_word(ACT_CTL_RD, REG_SYNC, '0);
        push_word(ACT_CTL_WR, REG_SPACING, PROM_OFF_WORD);
        push_word(ACT_CTL_RD, REG_SYNC, '0);
        push_word(ACT_CTL_WR, REG_SYNC, 32'hFFFF_FF5A);
        push_word(ACT_CTL_RD, REG_SYNC, '0);
        push_word(ACT_CTL_RD, REG_PTR, '0);
        push_word(ACT_CTL_RD, REG_SPACING, '0);
        push_word(ACT_CTL_WR, REG_FIRST_BAD, '1);
        push_word(ACT_CTL_RD, OFFSET_MAX, '0);
        push_word(ACT_CTL_WR, REG_SPACING, ~PROM_OFF_WORD);
        push_word(ACT_CTL_RD, REG_SYNC, '0);
        push_word(ACT_CTL_WR, REG_MODE, '1);
        push_word(ACT_CTL_RD, REG_MODE, '0);
        for (int a = ACT_RSVD_LO; a <= ACT_RSVD_HI; a++) begin
            push_word(ACTION_W'(a), OFFSET_W'($urandom), $urandom);
        end

        foreach (scr_pool[i]) scr_pool[i] = OFFSET_W'($urandom_range(0, SCREEN_WORDS - 1));
        foreach (ptr_pool[i]) ptr_pool[i] = PTR_W'($urandom_range(0, SYNC_DEPTH - 1));
        busy_words = 0;

        while (busy_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            addr = ($urandom_range(0, 6) == 0) ? OFFSET_W'($urandom)
                                              : scr_pool[$urandom_range(0, SCR_POOL_N - 1)];
            ptr  = ptr_pool[$urandom_range(0, PTR_POOL_N - 1)];
            if (pick < 26) begin
                push_word(ACT_SCR_WR, addr, $urandom);
            end else if (pick < 46) begin
                push_word(ACT_SCR_RD, addr, $urandom);
            end else if (pick < 60) begin
                // sync RAM round trip: unlock, point, write, re-point, read
                push_word(ACT_CTL_WR, REG_SPACING, $urandom | PROM_OFF_WORD);
                d = $urandom;
                d[PTR_W-1:0] = ptr;
                push_word(ACT_CTL_WR, REG_PTR, d);
                push_word(ACT_CTL_WR, REG_SYNC, $urandom);
                d = $urandom;
                d[PTR_W-1:0] = ptr;
                push_word(ACT_CTL_WR, REG_PTR, d);
                push_word(ACT_CTL_RD, REG_SYNC, $urandom);
            end else if (pick < 67) begin
                d = $urandom;
                d[MODE_INTR_EN_BIT] = $urandom_range(0, 2) != 0;
                push_word(ACT_CTL_WR, REG_MODE, d);
            end else if (pick < 75) begin
                push_word(ACT_VSYNC, OFFSET_W'($urandom), $urandom);
            end else if (pick < 81) begin
                push_word(ACT_CTL_RD, $urandom_range(0, 1) ? REG_MODE : REG_SYNC, $urandom);
            end else if (pick < 87) begin
                if ($urandom_range(0, 2) == 0) begin
                    push_word(ACT_CTL_RD, $urandom_range(0, 1) ? REG_PTR : REG_SPACING,
                              $urandom);
                end else begin
                    addr = $urandom_range(0, 1)
                         ? OFFSET_W'($urandom_range(REG_FIRST_BAD, REG_FIRST_BAD + 3))
                         : OFFSET_W'($urandom_range(REG_FIRST_BAD, OFFSET_MAX));
                    push_word($urandom_range(0, 1) ? ACT_CTL_RD : ACT_CTL_WR, addr, $urandom);
                end
            end else if (pick < 93) begin
                push_word(ACT_CTL_WR, $urandom_range(0, 1) ? REG_SPACING : REG_PTR, $urandom);
            end else if (pick < 97) begin
                push_word($urandom_range(0, 1) ? ACT_CTL_RD : ACT_CTL_WR, REG_SYNC, $urandom);
            end else begin
                push_word(ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)),
                          OFFSET_W'($urandom), $urandom);
            end
        end
        total_words = bus_words.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < total_words || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
